// ----- sv/wafc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wafc_pkg;

    // fixed point format and datapath widths
    localparam int FRAC_BITS = 40;
    localparam int DW        = 64;
    localparam int PW        = 2 * DW;
    localparam int ADDR_W    = 6;

    // pipeline depths of the iterative units
    localparam int SQRT_LAT  = DW;
    localparam int DIV_STEPS = DW;
    localparam int DIV_LAT   = DIV_STEPS + 2;

    localparam logic [DW-1:0] SIGN_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] POS_MAX  = {1'b0, {(DW-1){1'b1}}};

    // register map, index = paddr / 8
    localparam logic [2:0] REG_WALL_STYLE = 3'd0;
    localparam logic [2:0] REG_WALL_LO    = 3'd1;
    localparam logic [2:0] REG_WALL_HI    = 3'd2;
    localparam logic [2:0] REG_CYL_RADIUS = 3'd3;
    localparam logic [2:0] REG_STIFFNESS  = 3'd4;

    typedef enum logic [1:0] {
        STYLE_X,
        STYLE_Y,
        STYLE_Z,
        STYLE_CYL
    } wall_style_t;

    // per-particle sideband that travels down the pipeline
    typedef struct packed {
        logic          act;
        logic          last;
        wall_style_t   style;
        logic [DW-2:0] mass;
        logic [DW-2:0] rad;
        logic [DW-1:0] xm;
        logic [DW-1:0] ym;
        logic          xn;
        logic          yn;
        logic [DW-1:0] pm;
        logic          pn;
        logic [DW-1:0] delxy;
        logic          rneg;
        logic [DW-1:0] rm;
        logic          well_in;
        logic          axis;
        logic [DW-1:0] dm0;
        logic [DW-1:0] dm1;
        logic [DW-1:0] dm2;
        logic          dn0;
        logic          dn1;
        logic          dn2;
        logic          live;
        logic          ok;
        logic [DW-1:0] r;
        logic          deln;
        logic [DW-1:0] delm;
        logic          rz;
        logic [DW-1:0] cm;
        logic          fn0;
        logic          fn1;
        logic          fn2;
    } item_t;

    function automatic logic [DW-1:0] cap(input logic neg);
        return neg ? SIGN_MIN : POS_MAX;
    endfunction

    // saturating a - b on two's complement words
    function automatic logic [DW-1:0] ssub(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW-1:0] r;
        logic [DW-1:0] res;
        r   = a - b;
        res = r;
        if ((a[DW-1] ^ b[DW-1]) && (r[DW-1] ^ a[DW-1]))
        begin
            res = a[DW-1] ? SIGN_MIN : POS_MAX;
        end
        return res;
    endfunction

    // q-format product scaling with magnitude saturation
    function automatic logic [DW-1:0] qsat(input logic [PW-1:0] p, input logic neg);
        logic [PW-1:0] s;
        logic [DW-1:0] c;
        s = p >> FRAC_BITS;
        c = cap(neg);
        return (s > {{(PW-DW){1'b0}}, c}) ? c : s[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] sign_apply(input logic [DW-1:0] mag, input logic neg);
        return neg ? (~mag + 1'b1) : mag;
    endfunction

endpackage

`default_nettype wire

// ----- sv/wafc_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

// 64x64 unsigned multiply, partial products then sum, two register stages
module wafc_mul (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [wafc_pkg::DW-1:0]  a,
    input  wire logic [wafc_pkg::DW-1:0]  b,
    output logic      [wafc_pkg::PW-1:0]  p
);

    localparam int HW = wafc_pkg::DW / 2;

    logic [wafc_pkg::DW-1:0] pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [wafc_pkg::DW-1:0] pp00_next, pp01_next, pp10_next, pp11_next;
    logic [wafc_pkg::PW-1:0] p_reg, p_next;

    always_comb
    begin
        pp00_next = {{HW{1'b0}}, a[HW-1:0]} * {{HW{1'b0}}, b[HW-1:0]};
        pp01_next = {{HW{1'b0}}, a[HW-1:0]} * {{HW{1'b0}}, b[wafc_pkg::DW-1:HW]};
        pp10_next = {{HW{1'b0}}, a[wafc_pkg::DW-1:HW]} * {{HW{1'b0}}, b[HW-1:0]};
        pp11_next = {{HW{1'b0}}, a[wafc_pkg::DW-1:HW]} * {{HW{1'b0}}, b[wafc_pkg::DW-1:HW]};
        p_next = {pp11_reg, pp00_reg}
               + {{HW{1'b0}}, pp01_reg, {HW{1'b0}}}
               + {{HW{1'b0}}, pp10_reg, {HW{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp00_reg <= pp00_next;
            pp01_reg <= pp01_next;
            pp10_reg <= pp10_next;
            pp11_reg <= pp11_next;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ----- sv/wafc_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none

// floor square root, one root bit per stage
module wafc_sqrt (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [wafc_pkg::PW-1:0]  radicand,
    output logic      [wafc_pkg::DW-1:0]  root
);

    localparam int N  = wafc_pkg::SQRT_LAT;
    localparam int TW = wafc_pkg::PW + 2;

    logic [wafc_pkg::PW-1:0] rem_reg  [N];
    logic [wafc_pkg::DW-1:0] root_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_step
        localparam int B = N - 1 - i;
        logic [wafc_pkg::PW-1:0] rem_in, rem_next;
        logic [wafc_pkg::DW-1:0] root_in, root_next;
        logic [TW-1:0]           trial;
        logic                    take;

        if (i == 0)
        begin : g_first
            assign rem_in  = radicand;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
        end

        always_comb
        begin
            // (2*root + 2^b) * 2^b: root holds only bits above b
            trial     = ({{(TW-wafc_pkg::DW){1'b0}}, root_in} << (B + 1))
                      | ({{(TW-1){1'b0}}, 1'b1} << (2 * B));
            take      = {2'b00, rem_in} >= trial;
            rem_next  = take ? (rem_in - trial[wafc_pkg::PW-1:0]) : rem_in;
            root_next = take ? (root_in | ({{(wafc_pkg::DW-1){1'b0}}, 1'b1} << B)) : root_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
            end
        end
    end

    assign root = root_reg[N-1];

endmodule

`default_nettype wire

// ----- sv/wafc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// 128/64 restoring divide, one quotient bit per stage, saturated magnitude out
module wafc_div (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [wafc_pkg::PW-1:0]  num,
    input  wire logic [wafc_pkg::DW-1:0]  den,
    input  wire logic                     neg,
    output logic      [wafc_pkg::DW-1:0]  quo
);

    localparam int N  = wafc_pkg::DIV_STEPS;
    localparam int DW = wafc_pkg::DW;

    // entry stage: quotient overflows 64 bits when the high half is not below den
    logic          ovf0_reg, neg0_reg;
    logic [DW-1:0] rem0_reg, lo0_reg, den0_reg;

    logic          ovf_reg [N];
    logic          neg_reg [N];
    logic [DW-1:0] rem_reg [N];
    logic [DW-1:0] lo_reg  [N];
    logic [DW-1:0] den_reg [N];

    logic [DW-1:0] quo_reg, quo_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf0_reg <= num[wafc_pkg::PW-1:DW] >= den;
            neg0_reg <= neg;
            rem0_reg <= num[wafc_pkg::PW-1:DW];
            lo0_reg  <= num[DW-1:0];
            den0_reg <= den;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic          ovf_in, neg_in;
        logic [DW-1:0] rem_in, lo_in, den_in;
        logic [DW:0]   shifted, diff;
        logic          take;
        logic [DW-1:0] rem_next, lo_next;

        if (i == 0)
        begin : g_first
            assign ovf_in = ovf0_reg;
            assign neg_in = neg0_reg;
            assign rem_in = rem0_reg;
            assign lo_in  = lo0_reg;
            assign den_in = den0_reg;
        end
        else
        begin : g_rest
            assign ovf_in = ovf_reg[i-1];
            assign neg_in = neg_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign lo_in  = lo_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        always_comb
        begin
            shifted  = {rem_in, lo_in[DW-1]};
            diff     = shifted - {1'b0, den_in};
            take     = shifted >= {1'b0, den_in};
            rem_next = take ? diff[DW-1:0] : shifted[DW-1:0];
            // quotient bits enter at the bottom as numerator bits leave the top
            lo_next  = {lo_in[DW-2:0], take};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ovf_reg[i] <= ovf_in;
                neg_reg[i] <= neg_in;
                rem_reg[i] <= rem_next;
                lo_reg[i]  <= lo_next;
                den_reg[i] <= den_in;
            end
        end
    end

    always_comb
    begin
        quo_next = (ovf_reg[N-1] || (lo_reg[N-1] > wafc_pkg::cap(neg_reg[N-1])))
                 ? wafc_pkg::cap(neg_reg[N-1]) : lo_reg[N-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

// ----- sv/wall_adhesion_force.sv -----
`timescale 1ns / 1ps
`default_nettype none

// wall adhesion spring force, one particle per transfer
//
// input channel: in_valid / in_stall with the particle fields; a transfer
// happens on a clock edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with the force increment, contact
// flag and end-of-set mark; exactly one result per input transfer, in order
// config: apb-style port, 64-bit data, register i at byte address 8*i;
// write only while the pipeline is empty
//
// depth: the two 64-stage square roots and the 66-stage divide pipelines
// set the pipeline depth; throughput: one particle per cycle while no
// receiver stall freezes the pipeline, every stage holds its own item
// receiver stall: out_valid with out_stall freezes the whole pipeline and
// in_stall rises in the same cycle, so nothing is lost or repeated; bubbles
// are not squeezed out while frozen
// reset: all valid bits clear, registers go to x-style walls at the range
// extremes, zero radius and zero stiffness
module wall_adhesion_force (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // config port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [wafc_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [wafc_pkg::DW-1:0]            pwdata,
    output logic      [wafc_pkg::DW-1:0]            prdata,
    output logic                                    pready,
    // particle input
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [wafc_pkg::DW-1:0]     pos_x,
    input  wire logic signed [wafc_pkg::DW-1:0]     pos_y,
    input  wire logic signed [wafc_pkg::DW-1:0]     pos_z,
    input  wire logic [wafc_pkg::DW-2:0]            outer_rad,
    input  wire logic [wafc_pkg::DW-2:0]            body_mass,
    input  wire logic [wafc_pkg::DW-2:0]            shell_mass,
    input  wire logic                               in_fix_group,
    input  wire logic                               in_eps_group,
    input  wire logic                               last_particle,
    // force output
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [wafc_pkg::DW-1:0]          force_x,
    output logic signed [wafc_pkg::DW-1:0]          force_y,
    output logic signed [wafc_pkg::DW-1:0]          force_z,
    output logic                                    contact,
    output logic                                    last_result
);

    localparam int DW = wafc_pkg::DW;
    localparam int PW = wafc_pkg::PW;
    localparam int SL = wafc_pkg::SQRT_LAT;
    localparam int DL = wafc_pkg::DIV_LAT;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    wafc_pkg::wall_style_t wall_style_reg;
    logic [DW-1:0]         wall_lo_reg, wall_hi_reg;
    logic [DW-2:0]         cyl_radius_reg, stiffness_reg;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_style_reg <= wafc_pkg::STYLE_X;
            wall_lo_reg    <= wafc_pkg::SIGN_MIN;
            wall_hi_reg    <= wafc_pkg::POS_MAX;
            cyl_radius_reg <= '0;
            stiffness_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[5:3])
                wafc_pkg::REG_WALL_STYLE: wall_style_reg <= wafc_pkg::wall_style_t'(pwdata[1:0]);
                wafc_pkg::REG_WALL_LO:    wall_lo_reg    <= pwdata;
                wafc_pkg::REG_WALL_HI:    wall_hi_reg    <= pwdata;
                wafc_pkg::REG_CYL_RADIUS: cyl_radius_reg <= pwdata[DW-2:0];
                wafc_pkg::REG_STIFFNESS:  stiffness_reg  <= pwdata[DW-2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            wafc_pkg::REG_WALL_STYLE: prdata = {{(DW-2){1'b0}}, wall_style_reg};
            wafc_pkg::REG_WALL_LO:    prdata = wall_lo_reg;
            wafc_pkg::REG_WALL_HI:    prdata = wall_hi_reg;
            wafc_pkg::REG_CYL_RADIUS: prdata = {1'b0, cyl_radius_reg};
            wafc_pkg::REG_STIFFNESS:  prdata = {1'b0, stiffness_reg};
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // global advance: the output register is the only place a stall lands
    // ------------------------------------------------------------------
    logic out_vld_reg;
    logic adv;

    assign adv      = !(out_vld_reg && out_stall);
    assign in_stall = !adv;

    // ------------------------------------------------------------------
    // stage registers
    // ------------------------------------------------------------------
    wafc_pkg::item_t a_reg, b_reg, c_reg, d_reg, f_reg, g_reg, h_reg;
    wafc_pkg::item_t j_reg, k_reg, l_reg, m_reg, n_reg, o_reg;
    wafc_pkg::item_t q_reg, r_reg, s_reg, t_reg, u_reg, v_reg, w_reg, x_reg, y_reg;
    wafc_pkg::item_t a_next, b_next, d_next, f_next, g_next, h_next;
    wafc_pkg::item_t j_next, m_next, o_next, q_next, t_next, w_next;

    logic a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, f_vld_reg, g_vld_reg, h_vld_reg;
    logic j_vld_reg, k_vld_reg, l_vld_reg, m_vld_reg, n_vld_reg, o_vld_reg;
    logic q_vld_reg, r_vld_reg, s_vld_reg, t_vld_reg, u_vld_reg, v_vld_reg;
    logic w_vld_reg, x_vld_reg, y_vld_reg;

    // delay lines beside the square root and divide units
    wafc_pkg::item_t e_dly_reg [SL];
    wafc_pkg::item_t i_dly_reg [DL];
    wafc_pkg::item_t p_dly_reg [SL];
    wafc_pkg::item_t z_dly_reg [DL];
    logic [SL-1:0]   e_vld_reg, p_vld_reg;
    logic [DL-1:0]   i_vld_reg, z_vld_reg;

    // wide datapath registers
    logic [DW-1:0] a_d1_reg, a_d2_reg, a_d1_next, a_d2_next;
    logic [PW-1:0] d_sum_reg, d_sum_next;
    logic [PW-1:0] m_s01_reg, m_p2_reg, m_lim_reg;
    logic [PW-1:0] n_rsq_reg, n_lim_reg;
    logic [PW-1:0] o_rsq_reg;

    // output register
    logic [DW-1:0] out_fx_reg, out_fy_reg, out_fz_reg;
    logic [DW-1:0] out_fx_next, out_fy_next, out_fz_next;
    logic          out_contact_reg, out_last_reg, out_contact_next;

    // unit results
    logic [PW-1:0] mxx_p, myy_p, mrx_p, mry_p;
    logic [PW-1:0] msq0_p, msq1_p, msq2_p, mrr_p;
    logic [PW-1:0] mk_p, mm_p, mf0_p, mf1_p, mf2_p;
    logic [DW-1:0] delxy_root, r_root;
    logic [DW-1:0] dvx_q, dvy_q, dv0_q, dv1_q, dv2_q;

    wafc_pkg::item_t e_last, i_last, p_last, z_last;

    assign e_last = e_dly_reg[SL-1];
    assign i_last = i_dly_reg[DL-1];
    assign p_last = p_dly_reg[SL-1];
    assign z_last = z_dly_reg[DL-1];

    // ------------------------------------------------------------------
    // stage a: capture, mass select, plane distances, xy magnitudes
    // ------------------------------------------------------------------
    logic [DW-1:0] plane_pos;
    logic [DW-2:0] mass_sel;

    always_comb
    begin
        case (wall_style_reg)
            wafc_pkg::STYLE_X:   plane_pos = pos_x;
            wafc_pkg::STYLE_Y:   plane_pos = pos_y;
            wafc_pkg::STYLE_Z:   plane_pos = pos_z;
            wafc_pkg::STYLE_CYL: plane_pos = pos_x;
            default:             plane_pos = pos_x;
        endcase
        mass_sel = in_eps_group ? body_mass : shell_mass;

        a_next       = '0;
        a_next.act   = in_fix_group && (mass_sel != '0);
        a_next.last  = last_particle;
        a_next.style = wall_style_reg;
        a_next.mass  = mass_sel;
        a_next.rad   = outer_rad;
        a_next.xn    = pos_x[DW-1];
        a_next.yn    = pos_y[DW-1];
        a_next.xm    = pos_x[DW-1] ? (~pos_x + 1'b1) : pos_x;
        a_next.ym    = pos_y[DW-1] ? (~pos_y + 1'b1) : pos_y;
        a_d1_next    = wafc_pkg::ssub(plane_pos, wall_lo_reg);
        a_d2_next    = wafc_pkg::ssub(wall_hi_reg, plane_pos);
    end

    // ------------------------------------------------------------------
    // stage b: nearer plane wall, signed distance split into sign/magnitude
    // ------------------------------------------------------------------
    logic [DW-1:0] plane_d;

    always_comb
    begin
        plane_d = ($signed(a_d1_reg) < $signed(a_d2_reg))
                ? a_d1_reg : wafc_pkg::ssub('0, a_d2_reg);
        b_next    = a_reg;
        b_next.pn = plane_d[DW-1];
        b_next.pm = plane_d[DW-1] ? (~plane_d + 1'b1) : plane_d;
    end

    // stage d: x^2 + y^2 for the cylinder radius
    always_comb
    begin
        d_next     = c_reg;
        d_sum_next = mxx_p + myy_p;
    end

    // ------------------------------------------------------------------
    // stages f-h: radial gap to the cylinder
    // ------------------------------------------------------------------
    always_comb
    begin
        f_next       = e_last;
        f_next.delxy = delxy_root;
        f_next.rneg  = delxy_root > {1'b0, cyl_radius_reg};
        f_next.rm    = f_next.rneg ? (delxy_root - {1'b0, cyl_radius_reg})
                                   : ({1'b0, cyl_radius_reg} - delxy_root);
    end

    always_comb
    begin
        g_next         = f_reg;
        g_next.well_in = !f_reg.rneg && (f_reg.rm > {1'b0, f_reg.rad});
        g_next.axis    = f_reg.delxy == '0;
    end

    always_comb
    begin
        h_next     = g_reg;
        h_next.dn0 = (!g_reg.rneg) != g_reg.xn;
        h_next.dn1 = (!g_reg.rneg) != g_reg.yn;
    end

    // ------------------------------------------------------------------
    // stage j: wall normal vector for every wall style
    // ------------------------------------------------------------------
    always_comb
    begin
        j_next      = i_last;
        j_next.dm0  = '0;
        j_next.dm1  = '0;
        j_next.dm2  = '0;
        j_next.dn0  = 1'b0;
        j_next.dn1  = 1'b0;
        j_next.dn2  = 1'b0;
        j_next.live = 1'b1;
        case (i_last.style)
            wafc_pkg::STYLE_X:
            begin
                j_next.dm0 = i_last.pm;
                j_next.dn0 = i_last.pn;
            end
            wafc_pkg::STYLE_Y:
            begin
                j_next.dm1 = i_last.pm;
                j_next.dn1 = i_last.pn;
            end
            wafc_pkg::STYLE_Z:
            begin
                j_next.dm2 = i_last.pm;
                j_next.dn2 = i_last.pn;
            end
            wafc_pkg::STYLE_CYL:
            begin
                if (i_last.well_in)
                begin
                    // well inside: normal points along z at the cylinder radius
                    j_next.dm2 = {1'b0, cyl_radius_reg};
                end
                else if (i_last.axis)
                begin
                    // on the axis the direction is undefined, no contact
                    j_next.live = 1'b0;
                end
                else
                begin
                    j_next.dm0 = dvx_q;
                    j_next.dm1 = dvy_q;
                    j_next.dn0 = i_last.dn0;
                    j_next.dn1 = i_last.dn1;
                end
            end
            default: j_next.live = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // stages m-o: |d|^2 against 2*rad^2
    // ------------------------------------------------------------------
    always_comb
    begin
        m_next = l_reg;
    end

    always_comb
    begin
        o_next    = n_reg;
        o_next.ok = n_rsq_reg <= n_lim_reg;
    end

    // ------------------------------------------------------------------
    // stage q: overlap with the particle radius
    // ------------------------------------------------------------------
    always_comb
    begin
        q_next      = p_last;
        q_next.r    = r_root;
        q_next.rz   = r_root == '0;
        q_next.deln = r_root > {1'b0, p_last.rad};
        q_next.delm = q_next.deln ? (r_root - {1'b0, p_last.rad})
                                  : ({1'b0, p_last.rad} - r_root);
    end

    // stage t: overlap * stiffness
    always_comb
    begin
        t_next    = s_reg;
        t_next.cm = wafc_pkg::qsat(mk_p, s_reg.deln);
    end

    // stage w: * mass, and the force sign per axis
    always_comb
    begin
        w_next     = v_reg;
        w_next.cm  = wafc_pkg::qsat(mm_p, v_reg.deln);
        w_next.fn0 = v_reg.dn0 != v_reg.deln;
        w_next.fn1 = v_reg.dn1 != v_reg.deln;
        w_next.fn2 = v_reg.dn2 != v_reg.deln;
    end

    // ------------------------------------------------------------------
    // output stage: sign the force, zero it without contact
    // ------------------------------------------------------------------
    always_comb
    begin
        out_contact_next = z_last.act && z_last.live && z_last.ok && !z_last.rz;
        out_fx_next = out_contact_next ? wafc_pkg::sign_apply(dv0_q, z_last.fn0) : '0;
        out_fy_next = out_contact_next ? wafc_pkg::sign_apply(dv1_q, z_last.fn1) : '0;
        out_fz_next = out_contact_next ? wafc_pkg::sign_apply(dv2_q, z_last.fn2) : '0;
    end

    // ------------------------------------------------------------------
    // valid bits travel with the items
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= '0;
            f_vld_reg   <= 1'b0;
            g_vld_reg   <= 1'b0;
            h_vld_reg   <= 1'b0;
            i_vld_reg   <= '0;
            j_vld_reg   <= 1'b0;
            k_vld_reg   <= 1'b0;
            l_vld_reg   <= 1'b0;
            m_vld_reg   <= 1'b0;
            n_vld_reg   <= 1'b0;
            o_vld_reg   <= 1'b0;
            p_vld_reg   <= '0;
            q_vld_reg   <= 1'b0;
            r_vld_reg   <= 1'b0;
            s_vld_reg   <= 1'b0;
            t_vld_reg   <= 1'b0;
            u_vld_reg   <= 1'b0;
            v_vld_reg   <= 1'b0;
            w_vld_reg   <= 1'b0;
            x_vld_reg   <= 1'b0;
            y_vld_reg   <= 1'b0;
            z_vld_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg   <= in_valid;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            d_vld_reg   <= c_vld_reg;
            e_vld_reg   <= {e_vld_reg[SL-2:0], d_vld_reg};
            f_vld_reg   <= e_vld_reg[SL-1];
            g_vld_reg   <= f_vld_reg;
            h_vld_reg   <= g_vld_reg;
            i_vld_reg   <= {i_vld_reg[DL-2:0], h_vld_reg};
            j_vld_reg   <= i_vld_reg[DL-1];
            k_vld_reg   <= j_vld_reg;
            l_vld_reg   <= k_vld_reg;
            m_vld_reg   <= l_vld_reg;
            n_vld_reg   <= m_vld_reg;
            o_vld_reg   <= n_vld_reg;
            p_vld_reg   <= {p_vld_reg[SL-2:0], o_vld_reg};
            q_vld_reg   <= p_vld_reg[SL-1];
            r_vld_reg   <= q_vld_reg;
            s_vld_reg   <= r_vld_reg;
            t_vld_reg   <= s_vld_reg;
            u_vld_reg   <= t_vld_reg;
            v_vld_reg   <= u_vld_reg;
            w_vld_reg   <= v_vld_reg;
            x_vld_reg   <= w_vld_reg;
            y_vld_reg   <= x_vld_reg;
            z_vld_reg   <= {z_vld_reg[DL-2:0], y_vld_reg};
            out_vld_reg <= z_vld_reg[DL-1];
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg     <= a_next;
            a_d1_reg  <= a_d1_next;
            a_d2_reg  <= a_d2_next;
            b_reg     <= b_next;
            c_reg     <= b_reg;
            d_reg     <= d_next;
            d_sum_reg <= d_sum_next;
            e_dly_reg[0] <= d_reg;
            for (int i = 1; i < SL; i++)
            begin
                e_dly_reg[i] <= e_dly_reg[i-1];
            end
            f_reg <= f_next;
            g_reg <= g_next;
            h_reg <= h_next;
            i_dly_reg[0] <= h_reg;
            for (int i = 1; i < DL; i++)
            begin
                i_dly_reg[i] <= i_dly_reg[i-1];
            end
            j_reg     <= j_next;
            k_reg     <= j_reg;
            l_reg     <= k_reg;
            m_reg     <= m_next;
            m_s01_reg <= msq0_p + msq1_p;
            m_p2_reg  <= msq2_p;
            m_lim_reg <= {mrr_p[PW-2:0], 1'b0};
            n_reg     <= m_reg;
            n_rsq_reg <= m_s01_reg + m_p2_reg;
            n_lim_reg <= m_lim_reg;
            o_reg     <= o_next;
            o_rsq_reg <= n_rsq_reg;
            p_dly_reg[0] <= o_reg;
            for (int i = 1; i < SL; i++)
            begin
                p_dly_reg[i] <= p_dly_reg[i-1];
            end
            q_reg <= q_next;
            r_reg <= q_reg;
            s_reg <= r_reg;
            t_reg <= t_next;
            u_reg <= t_reg;
            v_reg <= u_reg;
            w_reg <= w_next;
            x_reg <= w_reg;
            y_reg <= x_reg;
            z_dly_reg[0] <= y_reg;
            for (int i = 1; i < DL; i++)
            begin
                z_dly_reg[i] <= z_dly_reg[i-1];
            end
            out_fx_reg      <= out_fx_next;
            out_fy_reg      <= out_fy_next;
            out_fz_reg      <= out_fz_next;
            out_contact_reg <= out_contact_next;
            out_last_reg    <= z_last.last;
        end
    end

    // ------------------------------------------------------------------
    // arithmetic units
    // ------------------------------------------------------------------
    // x^2, y^2 from stage a, ready beside stage c
    wafc_mul u_mxx (.clk(clk), .en(adv), .a(a_reg.xm), .b(a_reg.xm), .p(mxx_p));
    wafc_mul u_myy (.clk(clk), .en(adv), .a(a_reg.ym), .b(a_reg.ym), .p(myy_p));

    wafc_sqrt u_sqrt_xy (.clk(clk), .en(adv), .radicand(d_sum_reg), .root(delxy_root));

    // gap * x / delxy, gap * y / delxy
    wafc_mul u_mrx (.clk(clk), .en(adv), .a(f_reg.rm), .b(f_reg.xm), .p(mrx_p));
    wafc_mul u_mry (.clk(clk), .en(adv), .a(f_reg.rm), .b(f_reg.ym), .p(mry_p));

    wafc_div u_dvx (.clk(clk), .en(adv), .num(mrx_p), .den(h_reg.delxy),
                    .neg(h_reg.dn0), .quo(dvx_q));
    wafc_div u_dvy (.clk(clk), .en(adv), .num(mry_p), .den(h_reg.delxy),
                    .neg(h_reg.dn1), .quo(dvy_q));

    // |d|^2 terms and rad^2 from stage j
    wafc_mul u_msq0 (.clk(clk), .en(adv), .a(j_reg.dm0), .b(j_reg.dm0), .p(msq0_p));
    wafc_mul u_msq1 (.clk(clk), .en(adv), .a(j_reg.dm1), .b(j_reg.dm1), .p(msq1_p));
    wafc_mul u_msq2 (.clk(clk), .en(adv), .a(j_reg.dm2), .b(j_reg.dm2), .p(msq2_p));
    wafc_mul u_mrr  (.clk(clk), .en(adv), .a({1'b0, j_reg.rad}), .b({1'b0, j_reg.rad}),
                     .p(mrr_p));

    wafc_sqrt u_sqrt_r (.clk(clk), .en(adv), .radicand(o_rsq_reg), .root(r_root));

    // spring magnitude
    wafc_mul u_mk (.clk(clk), .en(adv), .a(q_reg.delm), .b({1'b0, stiffness_reg}),
                   .p(mk_p));
    wafc_mul u_mm (.clk(clk), .en(adv), .a(t_reg.cm), .b({1'b0, t_reg.mass}), .p(mm_p));

    // projection onto the normal: d_k * cm / |d|
    wafc_mul u_mf0 (.clk(clk), .en(adv), .a(w_reg.dm0), .b(w_reg.cm), .p(mf0_p));
    wafc_mul u_mf1 (.clk(clk), .en(adv), .a(w_reg.dm1), .b(w_reg.cm), .p(mf1_p));
    wafc_mul u_mf2 (.clk(clk), .en(adv), .a(w_reg.dm2), .b(w_reg.cm), .p(mf2_p));

    wafc_div u_dv0 (.clk(clk), .en(adv), .num(mf0_p), .den(y_reg.r), .neg(y_reg.fn0),
                    .quo(dv0_q));
    wafc_div u_dv1 (.clk(clk), .en(adv), .num(mf1_p), .den(y_reg.r), .neg(y_reg.fn1),
                    .quo(dv1_q));
    wafc_div u_dv2 (.clk(clk), .en(adv), .num(mf2_p), .den(y_reg.r), .neg(y_reg.fn2),
                    .quo(dv2_q));

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign out_valid   = out_vld_reg;
    assign force_x     = out_fx_reg;
    assign force_y     = out_fy_reg;
    assign force_z     = out_fz_reg;
    assign contact     = out_contact_reg;
    assign last_result = out_last_reg;

endmodule

`default_nettype wire

// ----- tb/sv/wall_adhesion_force_tb.sv -----
`timescale 1ns / 1ps

module wall_adhesion_force_tb;

    localparam int DW        = wafc_pkg::DW;
    localparam int PW        = wafc_pkg::PW;
    localparam int FRAC_BITS = wafc_pkg::FRAC_BITS;
    localparam int ADDR_W    = wafc_pkg::ADDR_W;

    // one particle as it crosses the input channel
    typedef struct {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
        logic [DW-2:0]        rad;
        logic [DW-2:0]        body;
        logic [DW-2:0]        shell;
        logic                 fix;
        logic                 eps;
        logic                 last;
    } particle_t;

    // one force increment as it leaves the output channel
    typedef struct packed {
        logic [DW-1:0] fx;
        logic [DW-1:0] fy;
        logic [DW-1:0] fz;
        logic          contact;
        logic          last;
    } wall_force_t;

    // scoreboard: predicts each accepted particle and checks results in order
    class adhesion_scoreboard;
        wafc_pkg::wall_style_t style;
        logic [DW-1:0] lo;
        logic [DW-1:0] hi;
        logic [DW-1:0] cyl;
        logic [DW-1:0] stiff;
        wall_force_t   expected_forces[$];
        int            errors;

        function new();
            style  = wafc_pkg::STYLE_X;
            lo     = wafc_pkg::SIGN_MIN;
            hi     = wafc_pkg::POS_MAX;
            cyl    = '0;
            stiff  = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [DW-1:0] val);
            case (idx)
                wafc_pkg::REG_WALL_STYLE: style = wafc_pkg::wall_style_t'(val[1:0]);
                wafc_pkg::REG_WALL_LO:    lo    = val;
                wafc_pkg::REG_WALL_HI:    hi    = val;
                wafc_pkg::REG_CYL_RADIUS: cyl   = {1'b0, val[DW-2:0]};
                wafc_pkg::REG_STIFFNESS:  stiff = {1'b0, val[DW-2:0]};
                default: ;
            endcase
        endfunction

        function logic [PW-1:0] wide_prod(logic [DW-1:0] a, logic [DW-1:0] b);
            logic [PW-1:0] aa;
            logic [PW-1:0] bb;
            aa = {{(PW-DW){1'b0}}, a};
            bb = {{(PW-DW){1'b0}}, b};
            return aa * bb;
        endfunction

        // saturate a magnitude to the limit of the given sign
        function logic [DW-1:0] clamp_mag(logic [PW-1:0] q, logic neg);
            logic [PW-1:0] c;
            c = {{(PW-DW){1'b0}}, (neg ? wafc_pkg::SIGN_MIN : wafc_pkg::POS_MAX)};
            return (q > c) ? c[DW-1:0] : q[DW-1:0];
        endfunction

        function logic [DW-1:0] qprod(logic [DW-1:0] a, logic [DW-1:0] b, logic neg);
            return clamp_mag(wide_prod(a, b) >> FRAC_BITS, neg);
        endfunction

        function logic [DW-1:0] scaled_quot(logic [DW-1:0] a, logic [DW-1:0] b,
                                            logic [DW-1:0] d, logic neg);
            logic [PW-1:0] dd;
            dd = {{(PW-DW){1'b0}}, d};
            return clamp_mag(wide_prod(a, b) / dd, neg);
        endfunction

        function logic [DW-1:0] floor_root(logic [PW-1:0] s);
            logic [DW-1:0] res;
            logic [DW-1:0] t;
            res = '0;
            for (int b = DW - 1; b >= 0; b--)
            begin
                t = res | (64'd1 << b);
                if (wide_prod(t, t) <= s)
                    res = t;
            end
            return res;
        endfunction

        function logic [DW-1:0] sub_sat(logic [DW-1:0] a, logic [DW-1:0] b);
            logic [DW-1:0] r;
            r = a - b;
            if ((a[DW-1] ^ b[DW-1]) && (r[DW-1] ^ a[DW-1]))
                return a[DW-1] ? wafc_pkg::SIGN_MIN : wafc_pkg::POS_MAX;
            return r;
        endfunction

        function wall_force_t adhesion_force(particle_t p);
            wall_force_t   f;
            logic [DW-1:0] rad;
            logic [DW-1:0] mass;
            logic [DW-1:0] dm[3];
            logic          dn[3];
            logic [DW-1:0] pv, d1, d2, d, xm, ym, delxy, rm, r, delm, cm, fo;
            logic          xn, yn, rneg, ok, deln, fn;
            logic [PW-1:0] rsq, lim;
            int            ax;
            f    = '0;
            f.last = p.last;
            rad  = {1'b0, p.rad};
            mass = p.eps ? {1'b0, p.body} : {1'b0, p.shell};
            ok   = 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                dm[k] = '0;
                dn[k] = 1'b0;
            end
            if (p.fix && mass != 0)
            begin
                if (style != wafc_pkg::STYLE_CYL)
                begin
                    ax = int'(style);
                    pv = (style == wafc_pkg::STYLE_X) ? p.x
                       : (style == wafc_pkg::STYLE_Y) ? p.y : p.z;
                    d1 = sub_sat(pv, lo);
                    d2 = sub_sat(hi, pv);
                    d  = ($signed(d1) < $signed(d2)) ? d1 : sub_sat('0, d2);
                    dn[ax] = d[DW-1];
                    dm[ax] = d[DW-1] ? -d : d;
                end
                else
                begin
                    xn = p.x[DW-1];
                    yn = p.y[DW-1];
                    xm = xn ? -p.x : p.x;
                    ym = yn ? -p.y : p.y;
                    delxy = floor_root(wide_prod(xm, xm) + wide_prod(ym, ym));
                    rneg  = delxy > cyl;
                    rm    = rneg ? delxy - cyl : cyl - delxy;
                    if (!rneg && rm > rad)
                        dm[2] = cyl;        // well inside the cylinder
                    else if (delxy == 0)
                        ok = 1'b0;          // on the axis
                    else
                    begin
                        dn[0] = (!rneg) != xn;
                        dn[1] = (!rneg) != yn;
                        dm[0] = scaled_quot(rm, xm, delxy, dn[0]);
                        dm[1] = scaled_quot(rm, ym, delxy, dn[1]);
                    end
                end
                if (ok)
                begin
                    rsq = wide_prod(dm[0], dm[0]) + wide_prod(dm[1], dm[1])
                        + wide_prod(dm[2], dm[2]);
                    lim = wide_prod(rad, rad);
                    lim = lim + lim;
                    if (rsq <= lim)
                    begin
                        r = floor_root(rsq);
                        if (r != 0)
                        begin
                            deln = r > rad;
                            delm = deln ? r - rad : rad - r;
                            cm   = qprod(delm, stiff, deln);
                            cm   = qprod(cm, mass, deln);
                            for (int k = 0; k < 3; k++)
                            begin
                                fn = dn[k] != deln;
                                fo = scaled_quot(dm[k], cm, r, fn);
                                fo = fn ? -fo : fo;
                                if (k == 0) f.fx = fo;
                                else if (k == 1) f.fy = fo;
                                else f.fz = fo;
                            end
                            f.contact = 1'b1;
                        end
                    end
                end
            end
            return f;
        endfunction

        function void note_input(particle_t p);
            expected_forces.push_back(adhesion_force(p));
        endfunction

        function void check_result(wall_force_t act);
            wall_force_t e;
            if (expected_forces.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: fx=%h fy=%h fz=%h", act.fx, act.fy, act.fz);
                return;
            end
            e = expected_forces.pop_front();
            if (e != act)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp fx=%h fy=%h fz=%h c=%b l=%b, %s",
                             e.fx, e.fy, e.fz, e.contact, e.last,
                             $sformatf("got fx=%h fy=%h fz=%h c=%b l=%b",
                                       act.fx, act.fy, act.fz, act.contact, act.last));
            end
        endfunction

        function int pending();
            return expected_forces.size();
        endfunction
    endclass

    localparam int          LIMIT    = 2000000;
    localparam int          PHASES   = 10;
    localparam int          PER_PH   = 150;
    localparam int          DRAIN    = 320;
    localparam int          HOLD_LEN = 700;
    localparam logic [63:0] ONE      = 64'd1 << FRAC_BITS;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DW-1:0]        pwdata;
    logic [DW-1:0]        prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [DW-1:0] pos_x;
    logic signed [DW-1:0] pos_y;
    logic signed [DW-1:0] pos_z;
    logic [DW-2:0]        outer_rad;
    logic [DW-2:0]        body_mass;
    logic [DW-2:0]        shell_mass;
    logic                 in_fix_group;
    logic                 in_eps_group;
    logic                 last_particle;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [DW-1:0] force_x;
    logic signed [DW-1:0] force_y;
    logic signed [DW-1:0] force_z;
    logic                 contact;
    logic                 last_result;

    adhesion_scoreboard sb = new();

    // idle percentages of the two sides, changed per phase
    int snd_idle_pct;
    int rcv_idle_pct;
    // long receiver hold-off: requests counted by the stimulus, served below
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles = 0;

    // testbench copy of the wall setup, used to aim particles at the walls
    wafc_pkg::wall_style_t cur_style;
    logic [DW-1:0] cur_lo, cur_hi, cur_cyl;

    wall_adhesion_force dut (.*);

    always #4 clk = ~clk;

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: check every result transfer, then pick the next stall value
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{force_x, force_y, force_z, contact, last_result});
        if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    // register write, setup then access; the write lands on the access-cycle edge
    task automatic write_reg(logic [2:0] idx, logic [DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // offer one particle and hold it until the transfer, then maybe idle
    task automatic send_particle(particle_t p);
        pos_x         <= p.x;
        pos_y         <= p.y;
        pos_z         <= p.z;
        outer_rad     <= p.rad;
        body_mass     <= p.body;
        shell_mass    <= p.shell;
        in_fix_group  <= p.fix;
        in_eps_group  <= p.eps;
        last_particle <= p.last;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(p);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic logic [DW-1:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // signed offset of up to +-2 radii, in thousandths of a radius
    function automatic logic [DW-1:0] near_offset(logic [DW-1:0] rad);
        longint off;
        off = (longint'($urandom_range(0, 4000)) - 2000) * (longint'(rad) / 1000);
        return off;
    endfunction

    function automatic particle_t random_particle();
        particle_t     p;
        logic [DW-1:0] base, rr, xv, rest;
        longint        frac;
        p.x     = rnd64();
        p.y     = rnd64();
        p.z     = rnd64();
        p.rad   = 63'(rnd64());
        p.body  = 63'(rnd64());
        p.shell = 63'(rnd64());
        p.fix   = 1'($urandom_range(1));
        p.eps   = 1'($urandom_range(1));
        p.last  = ($urandom_range(9) == 0);
        if ($urandom_range(99) < 20)
            return p;   // noise: every field at random
        // well-formed particle aimed at the wall
        p.rad   = (63'($urandom_range(1, 4)) << 38) | 63'($urandom);
        p.body  = (63'($urandom_range(0, 8)) << 37) | 63'($urandom);
        p.shell = (63'($urandom_range(0, 8)) << 37) | 63'($urandom);
        p.fix   = ($urandom_range(9) != 0);
        if (cur_style != wafc_pkg::STYLE_CYL)
        begin
            base = $urandom_range(1) ? cur_lo : cur_hi;
            base = base + near_offset({1'b0, p.rad});
            case (cur_style)
                wafc_pkg::STYLE_X: p.x = base;
                wafc_pkg::STYLE_Y: p.y = base;
                default:           p.z = base;
            endcase
        end
        else
        begin
            rr   = cur_cyl + near_offset({1'b0, p.rad});
            rr   = rr[DW-1] ? -rr : rr;
            frac = longint'($urandom_range(0, 2000)) - 1000;
            xv   = longint'(rr) / 1000 * frac;
            rest = sb.floor_root(sb.wide_prod(rr, rr) - sb.wide_prod(xv, xv));
            p.x  = xv;
            p.y  = $urandom_range(1) ? -rest : rest;
        end
        return p;
    endfunction

    // directed particles: field extremes, contact on the wall, axis, inactive
    function automatic particle_t corner_particle(int k);
        particle_t p;
        p = '{x: '0, y: '0, z: '0, rad: ONE[DW-2:0], body: ONE[DW-2:0],
              shell: ONE[DW-2:0], fix: 1'b1, eps: 1'b0, last: 1'b0};
        case (k)
            0: p = '{wafc_pkg::SIGN_MIN, wafc_pkg::SIGN_MIN, wafc_pkg::SIGN_MIN,
                     '1, '1, '1, 1'b1, 1'b1, 1'b1};
            1: p = '{wafc_pkg::POS_MAX, wafc_pkg::POS_MAX, wafc_pkg::POS_MAX,
                     '1, '0, '1, 1'b1, 1'b0, 1'b0};
            2:
            begin
                // on the lower wall, and on the cylinder axis
                p.x = (cur_style == wafc_pkg::STYLE_CYL) ? '0 : cur_lo;
                p.y = (cur_style == wafc_pkg::STYLE_CYL) ? '0 : cur_lo;
                p.z = cur_lo;
            end
            3:
            begin
                p.fix = 1'b0;
                p.x   = cur_hi;
                p.z   = cur_hi;
            end
            4:
            begin
                p.body  = '0;
                p.shell = '0;
                p.eps   = 1'b1;
                p.x     = cur_lo;
            end
            default:
            begin
                p.rad = '0;
                p.x   = cur_hi;
                p.y   = cur_hi;
                p.z   = cur_hi;
                p.last = 1'b1;
            end
        endcase
        return p;
    endfunction

    initial
    begin
        logic [DW-1:0] stiff_val;
        clk           = 1'b0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        pos_x         = '0;
        pos_y         = '0;
        pos_z         = '0;
        outer_rad     = '0;
        body_mass     = '0;
        shell_mass    = '0;
        in_fix_group  = 1'b0;
        in_eps_group  = 1'b0;
        last_particle = 1'b0;
        snd_idle_pct  = 0;
        rcv_idle_pct  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // idling pattern: sender light / receiver heavy, then swapped, then none
            snd_idle_pct = (ph < 3) ? 14 : (ph < 6) ? 82 : 0;
            rcv_idle_pct = (ph < 3) ? 82 : (ph < 6) ? 14 : 0;

            // wall setup for this phase, extremes in the last two
            cur_style = wafc_pkg::wall_style_t'(ph % 4);
            if (ph == 8)
            begin
                cur_lo    = wafc_pkg::SIGN_MIN;
                cur_hi    = wafc_pkg::POS_MAX;
                cur_cyl   = wafc_pkg::POS_MAX;
                stiff_val = wafc_pkg::POS_MAX;
            end
            else if (ph == 9)
            begin
                cur_lo    = wafc_pkg::POS_MAX;
                cur_hi    = wafc_pkg::SIGN_MIN;
                cur_cyl   = '0;
                stiff_val = '0;
            end
            else
            begin
                cur_lo    = -(64'($urandom_range(1, 50)) * ONE);
                cur_hi    = 64'($urandom_range(1, 50)) * ONE;
                cur_cyl   = 64'($urandom_range(1, 40)) * ONE + 64'($urandom);
                stiff_val = 64'($urandom_range(1, 1000)) << 30;
            end
            write_reg(wafc_pkg::REG_WALL_STYLE, 64'(cur_style));
            write_reg(wafc_pkg::REG_WALL_LO, cur_lo);
            write_reg(wafc_pkg::REG_WALL_HI, cur_hi);
            write_reg(wafc_pkg::REG_CYL_RADIUS, cur_cyl);
            write_reg(wafc_pkg::REG_STIFFNESS, stiff_val);

            for (int k = 0; k < PER_PH; k++)
            begin
                // long receiver hold-off while the sender keeps offering
                if (ph == 6 && k == 40)
                    hold_reqs++;
                if (ph < 4 && k < 6)
                    send_particle(corner_particle(k));
                else
                    send_particle(random_particle());
            end
            in_valid <= 1'b0;

            // drain before touching the registers again
            while (sb.pending() != 0)
                @(posedge clk);
            repeat (DRAIN) @(posedge clk);
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/wafc_pkg.sv
sv/wafc_mul.sv
sv/wafc_sqrt.sv
sv/wafc_div.sv
sv/wall_adhesion_force.sv
tb/sv/wall_adhesion_force_tb.sv
